// ===== rtl/core/euler_angles_to_up_vector_assert.svh =====
// Assertion macros used by the euler_angles_to_up_vector checker
`ifndef EULER_ANGLES_TO_UP_VECTOR_ASSERT_SVH
`define EULER_ANGLES_TO_UP_VECTOR_ASSERT_SVH

// same-cycle implication, disabled while rst_n is low
`define EAV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("eav assertion failed");

// next-cycle implication, disabled while rst_n is low
`define EAV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("eav assertion failed");

`endif

// ===== rtl/core/eav_pkg.sv =====
// Shared constants and types of the up vector datapath
`default_nettype none

package eav_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int OUT_FRAC_BITS_DEF = 14;

    localparam int IN_W    = 16;
    localparam int OUT_W   = 16;
    localparam int PHASE_W = 32;
    localparam int RES_W   = 30;   // quadrant residue
    localparam int X_W     = 31;   // radians, Q30, below pi/2
    localparam int X2_W    = 32;   // x squared, Q30
    localparam int TERM_W  = 31;   // Taylor term magnitude, Q30
    localparam int ACC_W   = 33;   // signed partial sum, Q30
    localparam int TRIG_W  = 32;   // folded sine / cosine, Q30

    localparam int NUM_CELLS    = 10;
    localparam int CELL_STAGES  = 3;
    localparam int FRONT_STAGES = 4;
    localparam int BACK_STAGES  = 6;
    localparam int LATENCY      = FRONT_STAGES + NUM_CELLS * CELL_STAGES + BACK_STAGES;

    localparam int PI_W     = 34;
    localparam int PI_SPLIT = 17;
    localparam logic [PI_W-1:0] PI_Q32 = 34'h3_243F_6A89;

    localparam logic [TERM_W-1:0] ONE_Q30 = 31'h4000_0000;

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } eav_quad_t;

    // running state of both Taylor series of one angle
    typedef struct packed {
        logic [TERM_W-1:0]        term_c;
        logic [TERM_W-1:0]        term_s;
        logic signed [ACC_W-1:0]  acc_c;
        logic signed [ACC_W-1:0]  acc_s;
        logic [X2_W-1:0]          x2;
    } eav_series_t;

endpackage

`default_nettype wire

// ===== rtl/core/eav_front.sv =====
// Angle to quadrant, radians and x squared, four register stages
`default_nettype none

module eav_front
    import eav_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic signed [IN_W-1:0] angle,
    output eav_series_t            series,
    output eav_quad_t              quad
);

    localparam int PHI_W  = PI_W - PI_SPLIT;
    localparam int PP_W   = RES_W + PHI_W;
    localparam int XF_W   = 64;
    localparam int SQ_W   = 2 * X_W;
    localparam logic [PHI_W-1:0]    PI_HI = PI_Q32[PI_W-1:PI_SPLIT];
    localparam logic [PI_SPLIT-1:0] PI_LO = PI_Q32[PI_SPLIT-1:0];

    logic signed [PHASE_W-1:0] ext;
    logic [PHASE_W-1:0]        phase;
    logic [XF_W-1:0]           x_full;
    logic [SQ_W-1:0]           sq;

    logic [RES_W-1:0] res_reg;
    eav_quad_t        quad1_reg, quad2_reg, quad3_reg, quad4_reg;
    logic [PP_W-1:0]  prod_hi_reg, prod_lo_reg;
    logic [X_W-1:0]   x_reg, x4_reg;
    logic [X2_W-1:0]  x2_reg;

    assign ext    = PHASE_W'(angle);
    assign phase  = ext << (PHASE_W - ANGLE_BITS);
    assign x_full = XF_W'({prod_hi_reg, {PI_SPLIT{1'b0}}}) + XF_W'(prod_lo_reg);
    assign sq     = SQ_W'(x_reg) * SQ_W'(x_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg     <= phase[RES_W-1:0];
            quad1_reg   <= eav_quad_t'(phase[PHASE_W-1:RES_W]);
            prod_hi_reg <= PP_W'(res_reg) * PP_W'(PI_HI);
            prod_lo_reg <= PP_W'(res_reg) * PP_W'(PI_LO);
            quad2_reg   <= quad1_reg;
            x_reg       <= x_full[XF_W-1:XF_W-X_W];
            quad3_reg   <= quad2_reg;
            x2_reg      <= sq[SQ_W-1:30];
            x4_reg      <= x_reg;
            quad4_reg   <= quad3_reg;
        end
    end

    assign series.term_c = ONE_Q30;
    assign series.acc_c  = $signed({2'b00, ONE_Q30});
    assign series.term_s = x4_reg;
    assign series.acc_s  = $signed({2'b00, x4_reg});
    assign series.x2     = x2_reg;
    assign quad          = quad4_reg;

endmodule

`default_nettype wire

// ===== rtl/core/eav_term_cell.sv =====
// One Taylor step for the sine and cosine series of one angle
`default_nettype none

module eav_term_cell
    import eav_pkg::*;
#(
    parameter int STEP = 1
) (
    input  logic        aclk,
    input  logic        en,
    input  eav_series_t din,
    output eav_series_t dout
);

    localparam int P_W      = TERM_W + X2_W;
    localparam int Q_W      = P_W - 30;
    localparam int REC_SH   = 33;
    localparam int REC_W    = 33;
    localparam int EST_W    = Q_W + REC_W;
    localparam int DIV_C    = (2 * STEP - 1) * (2 * STEP);
    localparam int DIV_S    = (2 * STEP) * (2 * STEP + 1);
    localparam logic [Q_W-1:0]   DIV_C_Q = Q_W'(DIV_C);
    localparam logic [Q_W-1:0]   DIV_S_Q = Q_W'(DIV_S);
    localparam logic [REC_W-1:0] REC_C   = REC_W'((64'd1 << REC_SH) / DIV_C);
    localparam logic [REC_W-1:0] REC_S   = REC_W'((64'd1 << REC_SH) / DIV_S);
    localparam logic             SUBTRACT = ((STEP % 2) == 1);

    logic [P_W-1:0]          prod_c_reg, prod_s_reg;
    logic [Q_W-1:0]          quo_c_reg, quo_s_reg;
    logic [EST_W-1:0]        est_c_reg, est_s_reg;
    logic signed [ACC_W-1:0] acc_c_a_reg, acc_s_a_reg, acc_c_b_reg, acc_s_b_reg;
    logic [X2_W-1:0]         x2_a_reg, x2_b_reg;
    eav_series_t             dout_reg, dout_next;

    logic [Q_W-1:0]    qe_c, qe_s, rem_c, rem_s;
    logic [TERM_W-1:0] term_c_new, term_s_new;

    // quotient estimate is exact or one low; one compare fixes it
    assign qe_c  = est_c_reg[EST_W-1:REC_SH];
    assign qe_s  = est_s_reg[EST_W-1:REC_SH];
    assign rem_c = quo_c_reg - qe_c * DIV_C_Q;
    assign rem_s = quo_s_reg - qe_s * DIV_S_Q;
    assign term_c_new = TERM_W'((rem_c >= DIV_C_Q) ? qe_c + 1'b1 : qe_c);
    assign term_s_new = TERM_W'((rem_s >= DIV_S_Q) ? qe_s + 1'b1 : qe_s);

    always_comb begin
        dout_next.term_c = term_c_new;
        dout_next.term_s = term_s_new;
        dout_next.x2     = x2_b_reg;
        if (SUBTRACT) begin
            dout_next.acc_c = acc_c_b_reg - $signed({2'b00, term_c_new});
            dout_next.acc_s = acc_s_b_reg - $signed({2'b00, term_s_new});
        end else begin
            dout_next.acc_c = acc_c_b_reg + $signed({2'b00, term_c_new});
            dout_next.acc_s = acc_s_b_reg + $signed({2'b00, term_s_new});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_c_reg  <= P_W'(din.term_c) * P_W'(din.x2);
            prod_s_reg  <= P_W'(din.term_s) * P_W'(din.x2);
            acc_c_a_reg <= din.acc_c;
            acc_s_a_reg <= din.acc_s;
            x2_a_reg    <= din.x2;
            quo_c_reg   <= prod_c_reg[P_W-1:30];
            quo_s_reg   <= prod_s_reg[P_W-1:30];
            est_c_reg   <= EST_W'(prod_c_reg[P_W-1:30]) * EST_W'(REC_C);
            est_s_reg   <= EST_W'(prod_s_reg[P_W-1:30]) * EST_W'(REC_S);
            acc_c_b_reg <= acc_c_a_reg;
            acc_s_b_reg <= acc_s_a_reg;
            x2_b_reg    <= x2_a_reg;
            dout_reg    <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

`default_nettype wire

// ===== rtl/core/eav_combine.sv =====
// Quadrant folding, rotation products, rounding and saturation
`default_nettype none

module eav_combine
    import eav_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    en,
    input  eav_series_t             roll,
    input  eav_series_t             pitch,
    input  eav_series_t             yaw,
    input  eav_quad_t               roll_quad,
    input  eav_quad_t               pitch_quad,
    input  eav_quad_t               yaw_quad,
    output logic signed [OUT_W-1:0] up_x,
    output logic signed [OUT_W-1:0] up_y,
    output logic signed [OUT_W-1:0] up_z
);

    localparam int PROD_W = 2 * TRIG_W;
    localparam int CRSP_W = PROD_W - 30;
    localparam int P2_W   = CRSP_W + TRIG_W;
    localparam int SUM_W  = P2_W + 1;
    localparam int SH     = 60 - OUT_FRAC_BITS;
    localparam logic signed [PROD_W-1:0] HALF30 = PROD_W'(64'sd1 <<< 29);
    localparam logic signed [SUM_W-1:0]  HALF   = SUM_W'(1) <<< (SH - 1);
    localparam longint SAT_HI_L = (OUT_FRAC_BITS >= 15) ? 32767 : (longint'(1) << OUT_FRAC_BITS);
    localparam longint SAT_LO_L = (OUT_FRAC_BITS >= 15) ? -32768 : -SAT_HI_L;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(SAT_HI_L);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(SAT_LO_L);

    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_v;
        logic signed [TRIG_W-1:0] cos_v;
    } trig_pair_t;

    function automatic trig_pair_t fold(input eav_quad_t q,
                                        input logic signed [ACC_W-1:0] s_acc,
                                        input logic signed [ACC_W-1:0] c_acc);
        trig_pair_t t;
        logic signed [TRIG_W-1:0] s;
        logic signed [TRIG_W-1:0] c;
        s = TRIG_W'(s_acc);
        c = TRIG_W'(c_acc);
        unique case (q)
            QUAD_I: begin
                t.sin_v = s;
                t.cos_v = c;
            end
            QUAD_II: begin
                t.sin_v = c;
                t.cos_v = -s;
            end
            QUAD_III: begin
                t.sin_v = -s;
                t.cos_v = -c;
            end
            QUAD_IV: begin
                t.sin_v = -c;
                t.cos_v = s;
            end
        endcase
        return t;
    endfunction

    // round half away from zero, then clamp to the output range
    function automatic logic signed [OUT_W-1:0] finish(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        r = (v + ((v < 0) ? HALF - 1 : HALF)) >>> SH;
        if (r > SAT_HI) begin
            r = SAT_HI;
        end else if (r < SAT_LO) begin
            r = SAT_LO;
        end
        return OUT_W'(r);
    endfunction

    trig_pair_t t_r, t_p, t_y;
    logic signed [PROD_W-1:0] crsp_rnd;

    logic signed [TRIG_W-1:0] sr_reg, cr_reg, sp_reg, cp_reg, sy_reg, cy_reg;
    logic signed [TRIG_W-1:0] sy2_reg, cy2_reg, sy3_reg, cy3_reg;
    logic signed [PROD_W-1:0] crsp_p_reg, srsy2_reg, srcy2_reg, z2_reg;
    logic signed [PROD_W-1:0] srsy3_reg, srcy3_reg, z3_reg, srsy4_reg, srcy4_reg, z4_reg;
    logic signed [CRSP_W-1:0] crsp_reg;
    logic signed [P2_W-1:0]   xa_reg, ya_reg;
    logic signed [SUM_W-1:0]  sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [OUT_W-1:0]  up_x_reg, up_y_reg, up_z_reg;

    assign t_r = fold(roll_quad, roll.acc_s, roll.acc_c);
    assign t_p = fold(pitch_quad, pitch.acc_s, pitch.acc_c);
    assign t_y = fold(yaw_quad, yaw.acc_s, yaw.acc_c);
    assign crsp_rnd = crsp_p_reg + ((crsp_p_reg < 0) ? HALF30 - 1 : HALF30);

    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg     <= t_r.sin_v;
            cr_reg     <= t_r.cos_v;
            sp_reg     <= t_p.sin_v;
            cp_reg     <= t_p.cos_v;
            sy_reg     <= t_y.sin_v;
            cy_reg     <= t_y.cos_v;
            crsp_p_reg <= PROD_W'(cr_reg) * PROD_W'(sp_reg);
            srsy2_reg  <= PROD_W'(sr_reg) * PROD_W'(sy_reg);
            srcy2_reg  <= PROD_W'(sr_reg) * PROD_W'(cy_reg);
            z2_reg     <= PROD_W'(cp_reg) * PROD_W'(cr_reg);
            sy2_reg    <= sy_reg;
            cy2_reg    <= cy_reg;
            crsp_reg   <= CRSP_W'(crsp_rnd >>> 30);
            srsy3_reg  <= srsy2_reg;
            srcy3_reg  <= srcy2_reg;
            z3_reg     <= z2_reg;
            sy3_reg    <= sy2_reg;
            cy3_reg    <= cy2_reg;
            xa_reg     <= P2_W'(crsp_reg) * P2_W'(cy3_reg);
            ya_reg     <= P2_W'(crsp_reg) * P2_W'(sy3_reg);
            srsy4_reg  <= srsy3_reg;
            srcy4_reg  <= srcy3_reg;
            z4_reg     <= z3_reg;
            sum_x_reg  <= SUM_W'(xa_reg) + SUM_W'(srsy4_reg);
            sum_y_reg  <= SUM_W'(ya_reg) - SUM_W'(srcy4_reg);
            sum_z_reg  <= SUM_W'(z4_reg);
            up_x_reg   <= finish(sum_x_reg);
            up_y_reg   <= finish(sum_y_reg);
            up_z_reg   <= finish(sum_z_reg);
        end
    end

    assign up_x = up_x_reg;
    assign up_y = up_y_reg;
    assign up_z = up_z_reg;

endmodule

`default_nettype wire

// ===== rtl/core/euler_angles_to_up_vector.sv =====
// Up vector of a Z-Y-X rotation: top level of the pipelined datapath
//
// Input channel s_*: roll, pitch and yaw as signed binary angles (2^ANGLE_BITS
// counts per turn; wrap-around is plain two's complement overflow). A transfer
// takes place when s_valid and s_ready are both high.
// Output channel m_*: up_x, up_y, up_z in signed fixed point with
// OUT_FRAC_BITS fraction bits (Q1.14 by default), one result per input item.
// Pipeline from input transfer to m_valid: 4 front stages for radians and
// x^2, ten Taylor cells of 3 stages each, 6 combine stages.
// Throughput: one item per cycle unless stalled; every stage holds its own item.
// Stall: the whole pipeline advances on one enable, which is high while the
// output register is empty or is being taken. When the receiver holds
// m_ready low with a result waiting, the pipe freezes and s_ready drops;
// bubbles in the pipe are not squeezed out.
// Reset (aresetn low, synchronous): all valid bits clear; no result is
// presented after reset until a new item has gone through.
`default_nettype none

module euler_angles_to_up_vector
    import eav_pkg::*;
#(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [IN_W-1:0]  s_roll_angle,
    input  logic signed [IN_W-1:0]  s_pitch_angle,
    input  logic signed [IN_W-1:0]  s_yaw_angle,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OUT_W-1:0] m_up_x,
    output logic signed [OUT_W-1:0] m_up_y,
    output logic signed [OUT_W-1:0] m_up_z
);

    localparam int NUM_ANGLES = 3;
    localparam int QLINE      = NUM_CELLS * CELL_STAGES;

    logic en;

    // one valid bit per pipeline stage
    logic [LATENCY-1:0] vld_reg, vld_next;

    logic signed [IN_W-1:0] angle_in   [NUM_ANGLES];
    eav_quad_t              front_quad [NUM_ANGLES];
    eav_series_t            chain      [NUM_ANGLES][NUM_CELLS+1];
    // quadrant rides beside the Taylor cells
    eav_quad_t              quad_line_reg [NUM_ANGLES][QLINE];

    assign en      = !vld_reg[LATENCY-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LATENCY-1];

    assign angle_in[0] = s_roll_angle;
    assign angle_in[1] = s_pitch_angle;
    assign angle_in[2] = s_yaw_angle;

    always_comb begin
        vld_next = vld_reg;
        if (en) begin
            vld_next = {vld_reg[LATENCY-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < NUM_ANGLES; a++) begin
                quad_line_reg[a][0] <= front_quad[a];
                for (int i = 1; i < QLINE; i++) begin
                    quad_line_reg[a][i] <= quad_line_reg[a][i-1];
                end
            end
        end
    end

    for (genvar a = 0; a < NUM_ANGLES; a++) begin : g_angle
        eav_front #(
            .ANGLE_BITS (ANGLE_BITS)
        ) u_front (
            .aclk   (aclk),
            .en     (en),
            .angle  (angle_in[a]),
            .series (chain[a][0]),
            .quad   (front_quad[a])
        );

        // cell k applies Taylor step k+1 to both series
        for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
            eav_term_cell #(
                .STEP (k + 1)
            ) u_cell (
                .aclk (aclk),
                .en   (en),
                .din  (chain[a][k]),
                .dout (chain[a][k+1])
            );
        end
    end

    eav_combine #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_combine (
        .aclk       (aclk),
        .en         (en),
        .roll       (chain[0][NUM_CELLS]),
        .pitch      (chain[1][NUM_CELLS]),
        .yaw        (chain[2][NUM_CELLS]),
        .roll_quad  (quad_line_reg[0][QLINE-1]),
        .pitch_quad (quad_line_reg[1][QLINE-1]),
        .yaw_quad   (quad_line_reg[2][QLINE-1]),
        .up_x       (m_up_x),
        .up_y       (m_up_y),
        .up_z       (m_up_z)
    );

endmodule

`default_nettype wire

// ===== rtl/core/eav_checker.sv =====
// Port-level checks of the up vector block, bound to the top level
`default_nettype none

`include "euler_angles_to_up_vector_assert.svh"

module eav_checker
    import eav_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [OUT_W-1:0] m_up_x,
    input logic signed [OUT_W-1:0] m_up_y,
    input logic signed [OUT_W-1:0] m_up_z
);

    localparam int LIM_I = (OUT_FRAC_BITS >= 15) ? 32767 : (1 << OUT_FRAC_BITS);
    localparam logic signed [OUT_W-1:0] LIM_HI = OUT_W'(LIM_I);
    localparam logic signed [OUT_W-1:0] LIM_LO = (OUT_FRAC_BITS >= 15) ? -16'sd32768 : -LIM_HI;

    logic [3*OUT_W-1:0] m_data;
    logic               in_range;

    assign m_data   = {m_up_x, m_up_y, m_up_z};
    assign in_range = m_up_x <= LIM_HI && m_up_x >= LIM_LO
                   && m_up_y <= LIM_HI && m_up_y >= LIM_LO
                   && m_up_z <= LIM_HI && m_up_z >= LIM_LO;

    // stalled result holds
    `EAV_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    // components stay inside the saturation range
    `EAV_ASSERT_IMPL(a_range, aclk, aresetn, m_valid, in_range)
    // a taken or empty output never blocks the input side
    `EAV_ASSERT_IMPL(a_flow, aclk, aresetn, m_ready || !m_valid, s_ready)
    // an offered input stays offered until it is taken
    `EAV_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid)
    // reset empties the pipe
    `EAV_ASSERT_NEXT(a_reset, aclk, 1'b1, !aresetn, !m_valid)

endmodule

bind euler_angles_to_up_vector eav_checker #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_eav_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_up_x  (m_up_x),
    .m_up_y  (m_up_y),
    .m_up_z  (m_up_z)
);

`default_nettype wire
